>>> hw/rtl/lckv_pkg.sv
// ----------------------------------------------------------------------------
// lckv_pkg
// Shared constants and types of the line command key/value store.
// ----------------------------------------------------------------------------
package lckv_pkg;

  localparam int unsigned ENTRIES   = 64;
  localparam int unsigned ENT_W     = 6;            // entry index bits
  localparam int unsigned CNT_W     = 7;            // entry count, holds ENTRIES
  localparam int unsigned KEY_CHARS = 31;
  localparam int unsigned VAL_CHARS = 31;
  localparam int unsigned CHR_W     = 5;            // character index and length bits
  localparam int unsigned TBL_AW    = ENT_W + CHR_W;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] PUT_WORD [3] = '{8'h70, 8'h75, 8'h74};

  typedef enum logic [1:0] {
    STATUS_STORED  = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_FOUND   = 2'd2,
    STATUS_MISSING = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_CMD   = 2'd0,
    PH_KEY   = 2'd1,
    PH_VALUE = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COPY,
    ST_PUT_FIN,
    ST_RESP,
    ST_LEN_RD,
    ST_LEN_CHK,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_VAL_RD,
    ST_VAL_OUT
  } state_e;

  typedef struct packed {
    logic             key_en;
    logic             val_en;
    logic [CHR_W-1:0] idx;
    logic [7:0]       data;
  } line_wr_t;

  typedef struct packed {
    logic              en;
    logic [TBL_AW-1:0] addr;
    logic [7:0]        key;
    logic [7:0]        val;
  } tbl_wr_t;

  typedef struct packed {
    logic             en;
    logic [ENT_W-1:0] entry;
    logic [CHR_W-1:0] key_len;
    logic [CHR_W-1:0] val_len;
  } len_wr_t;

endpackage

>>> hw/rtl/lckv_line_buf.sv
// ----------------------------------------------------------------------------
// lckv_line_buf
// Key and value buffers of the line being received, with registered reads.
// ----------------------------------------------------------------------------
module lckv_line_buf
  import lckv_pkg::*;
(
  input  logic             clk_i,
  input  line_wr_t         wr_i,
  input  logic [CHR_W-1:0] rd_idx_i,
  output logic [7:0]       key_rd_o,
  output logic [7:0]       val_rd_o
);

  logic [7:0] key_mem [2**CHR_W];
  logic [7:0] val_mem [2**CHR_W];
  logic [7:0] key_rd_q;
  logic [7:0] val_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.key_en) begin
      key_mem[wr_i.idx] <= wr_i.data;
    end
    if (wr_i.val_en) begin
      val_mem[wr_i.idx] <= wr_i.data;
    end
    key_rd_q <= key_mem[rd_idx_i];
    val_rd_q <= val_mem[rd_idx_i];
  end

  assign key_rd_o = key_rd_q;
  assign val_rd_o = val_rd_q;

endmodule

>>> hw/rtl/lckv_table.sv
// ----------------------------------------------------------------------------
// lckv_table
// Entry table: key and value characters plus their lengths per entry.
// ----------------------------------------------------------------------------
module lckv_table
  import lckv_pkg::*;
(
  input  logic              clk_i,
  input  tbl_wr_t           wr_i,
  input  len_wr_t           len_wr_i,
  input  logic [TBL_AW-1:0] rd_addr_i,
  input  logic [ENT_W-1:0]  len_rd_entry_i,
  output logic [7:0]        key_rd_o,
  output logic [7:0]        val_rd_o,
  output logic [CHR_W-1:0]  key_len_rd_o,
  output logic [CHR_W-1:0]  val_len_rd_o
);

  logic [7:0]       key_mem     [2**TBL_AW];
  logic [7:0]       val_mem     [2**TBL_AW];
  logic [CHR_W-1:0] key_len_mem [ENTRIES];
  logic [CHR_W-1:0] val_len_mem [ENTRIES];
  logic [7:0]       key_rd_q;
  logic [7:0]       val_rd_q;
  logic [CHR_W-1:0] key_len_rd_q;
  logic [CHR_W-1:0] val_len_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      key_mem[wr_i.addr] <= wr_i.key;
      val_mem[wr_i.addr] <= wr_i.val;
    end
    key_rd_q <= key_mem[rd_addr_i];
    val_rd_q <= val_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (len_wr_i.en) begin
      key_len_mem[len_wr_i.entry] <= len_wr_i.key_len;
      val_len_mem[len_wr_i.entry] <= len_wr_i.val_len;
    end
    key_len_rd_q <= key_len_mem[len_rd_entry_i];
    val_len_rd_q <= val_len_mem[len_rd_entry_i];
  end

  assign key_rd_o     = key_rd_q;
  assign val_rd_o     = val_rd_q;
  assign key_len_rd_o = key_len_rd_q;
  assign val_len_rd_o = val_len_rd_q;

endmodule

>>> hw/rtl/line_command_key_value_store_core.sv
// ----------------------------------------------------------------------------
// line_command_key_value_store_core
// Text line key/value store: "put KEY VALUE" appends, "get KEY" looks up.
// ----------------------------------------------------------------------------
// Input stream: one character per request in s_axis_tdata_i. Ordinary
// characters are taken one per cycle. On a newline the core stops taking
// requests until the line has been handled:
//   put: all 32 character slots of the line are copied into the table, then one
//        result (stored, or table full with no copy).
//   get: entries are scanned in insertion order, each by a length check
//        and then a compare of each key character, then the value
//        bytes follow, the final one marked with tlast, or a single
//        found result for an empty value, or a single not-found result.
// The cost is set by the single read port of the entry table memory.
// Results leave through one output register, so the next line's characters
// are taken while a put or miss result still waits for the receiver.
// A stalled receiver holds the value readout in place.
// Reset clears the parser and the entry count; table contents need no clear.
// ----------------------------------------------------------------------------
module line_command_key_value_store_core
  import lckv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [1:0] status, [9:2] value_byte, zero above
  output logic        m_axis_tuser_o,   // [0] byte_valid
  output logic        m_axis_tlast_o
);

  state_e           state_q, state_d;
  phase_e           phase_q, phase_d;
  logic             is_put_q, is_put_d;
  logic [1:0]       pos_q, pos_d;
  logic [CHR_W-1:0] klen_q, klen_d;
  logic [CHR_W-1:0] vlen_q, vlen_d;
  logic [CHR_W-1:0] line_klen_q, line_klen_d;
  logic [CHR_W-1:0] line_vlen_q, line_vlen_d;
  logic [CHR_W-1:0] ent_vlen_q, ent_vlen_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] ent_q, ent_d;
  logic [CHR_W-1:0] idx_q, idx_d;
  logic             cp_v_q, cp_v_d;
  logic [CHR_W-1:0] cp_idx_q;
  status_e          resp_q, resp_d;

  logic             out_v_q;
  status_e          out_status_q;
  logic [7:0]       out_byte_q;
  logic             out_bvalid_q;
  logic             out_last_q;
  logic             out_free;
  logic             load;
  status_e          ld_status;
  logic [7:0]       ld_byte;
  logic             ld_bvalid;
  logic             ld_last;

  line_wr_t         line_wr;
  tbl_wr_t          tbl_wr;
  len_wr_t          len_wr;
  logic [7:0]       line_key_rd, line_val_rd;
  logic [7:0]       tbl_key_rd, tbl_val_rd;
  logic [CHR_W-1:0] tbl_klen_rd, tbl_vlen_rd;
  logic             in_acc;
  logic [7:0]       ch;
  logic             line_put;

  lckv_line_buf u_line_buf (
    .clk_i    (clk_i),
    .wr_i     (line_wr),
    .rd_idx_i (idx_q),
    .key_rd_o (line_key_rd),
    .val_rd_o (line_val_rd)
  );

  lckv_table u_table (
    .clk_i          (clk_i),
    .wr_i           (tbl_wr),
    .len_wr_i       (len_wr),
    .rd_addr_i      ({ent_q[ENT_W-1:0], idx_q}),
    .len_rd_entry_i (ent_q[ENT_W-1:0]),
    .key_rd_o       (tbl_key_rd),
    .val_rd_o       (tbl_val_rd),
    .key_len_rd_o   (tbl_klen_rd),
    .val_len_rd_o   (tbl_vlen_rd)
  );

  assign out_free        = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign ch              = s_axis_tdata_i;
  assign line_put        = is_put_q && (pos_q == 2'd3);

  // copy pipeline: line buffer read, then table write in the next cycle
  assign tbl_wr.en   = cp_v_q;
  assign tbl_wr.addr = {count_q[ENT_W-1:0], cp_idx_q};
  assign tbl_wr.key  = line_key_rd;
  assign tbl_wr.val  = line_val_rd;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    is_put_d    = is_put_q;
    pos_d       = pos_q;
    klen_d      = klen_q;
    vlen_d      = vlen_q;
    line_klen_d = line_klen_q;
    line_vlen_d = line_vlen_q;
    ent_vlen_d  = ent_vlen_q;
    count_d     = count_q;
    ent_d       = ent_q;
    idx_d       = idx_q;
    cp_v_d      = 1'b0;
    resp_d      = resp_q;
    line_wr     = '0;
    line_wr.data = ch;
    len_wr      = '0;
    len_wr.entry   = count_q[ENT_W-1:0];
    len_wr.key_len = line_klen_q;
    len_wr.val_len = line_vlen_q;
    load        = 1'b0;
    ld_status   = resp_q;
    ld_byte     = '0;
    ld_bvalid   = 1'b0;
    ld_last     = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (ch == CH_NEWLINE) begin
            line_klen_d = (phase_q == PH_CMD) ? '0 : klen_q;
            line_vlen_d = (line_put && phase_q == PH_VALUE) ? vlen_q : '0;
            phase_d  = PH_CMD;
            is_put_d = 1'b1;
            pos_d    = '0;
            klen_d   = '0;
            vlen_d   = '0;
            idx_d    = '0;
            ent_d    = '0;
            if (line_put) begin
              if (count_q >= CNT_W'(ENTRIES)) begin
                resp_d  = STATUS_FULL;
                state_d = ST_RESP;
              end else begin
                state_d = ST_COPY;
              end
            end else begin
              state_d = ST_LEN_RD;
            end
          end else begin
            case (phase_q)
              PH_CMD: begin
                if (ch == CH_SPACE) begin
                  phase_d = PH_KEY;
                end else if (pos_q != 2'd3) begin
                  if (ch != PUT_WORD[pos_q]) begin
                    is_put_d = 1'b0;
                  end
                  pos_d = pos_q + 2'd1;
                end
              end
              PH_KEY: begin
                if (ch == CH_SPACE) begin
                  phase_d = PH_VALUE;
                end else if (klen_q < CHR_W'(KEY_CHARS)) begin
                  line_wr.key_en = 1'b1;
                  line_wr.idx    = klen_q;
                  klen_d         = klen_q + 1'b1;
                end
              end
              default: begin
                if (line_put && vlen_q < CHR_W'(VAL_CHARS)) begin
                  line_wr.val_en = 1'b1;
                  line_wr.idx    = vlen_q;
                  vlen_d         = vlen_q + 1'b1;
                end
              end
            endcase
          end
        end
      end
      ST_COPY: begin
        cp_v_d = 1'b1;
        idx_d  = idx_q + 1'b1;
        if (idx_q == '1) begin
          state_d = ST_PUT_FIN;
        end
      end
      ST_PUT_FIN: begin
        len_wr.en = 1'b1;
        count_d   = count_q + 1'b1;
        resp_d    = STATUS_STORED;
        state_d   = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_LEN_RD: begin
        idx_d = '0;
        if (ent_q == count_q) begin
          resp_d  = STATUS_MISSING;
          state_d = ST_RESP;
        end else begin
          state_d = ST_LEN_CHK;
        end
      end
      ST_LEN_CHK: begin
        ent_vlen_d = tbl_vlen_rd;
        if (tbl_klen_rd != line_klen_q) begin
          ent_d   = ent_q + 1'b1;
          state_d = ST_LEN_RD;
        end else if (line_klen_q == '0) begin
          state_d = ST_VAL_RD;
        end else begin
          state_d = ST_CMP_RD;
        end
      end
      ST_CMP_RD: begin
        state_d = ST_CMP_CHK;
      end
      ST_CMP_CHK: begin
        if (tbl_key_rd != line_key_rd) begin
          ent_d   = ent_q + 1'b1;
          state_d = ST_LEN_RD;
        end else if (idx_q + 1'b1 == line_klen_q) begin
          idx_d   = '0;
          state_d = ST_VAL_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_CMP_RD;
        end
      end
      ST_VAL_RD: begin
        if (ent_vlen_q == '0) begin
          resp_d  = STATUS_FOUND;
          state_d = ST_RESP;
        end else begin
          state_d = ST_VAL_OUT;
        end
      end
      ST_VAL_OUT: begin
        if (out_free) begin
          load      = 1'b1;
          ld_status = STATUS_FOUND;
          ld_byte   = tbl_val_rd;
          ld_bvalid = 1'b1;
          ld_last   = (idx_q + 1'b1 == ent_vlen_q);
          if (ld_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_VAL_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      phase_q  <= PH_CMD;
      is_put_q <= 1'b1;
      pos_q    <= '0;
      klen_q   <= '0;
      vlen_q   <= '0;
      count_q  <= '0;
      cp_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      is_put_q <= is_put_d;
      pos_q    <= pos_d;
      klen_q   <= klen_d;
      vlen_q   <= vlen_d;
      count_q  <= count_d;
      cp_v_q   <= cp_v_d;
      if (load) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    line_klen_q <= line_klen_d;
    line_vlen_q <= line_vlen_d;
    ent_vlen_q  <= ent_vlen_d;
    ent_q       <= ent_d;
    idx_q       <= idx_d;
    cp_idx_q    <= idx_q;
    resp_q      <= resp_d;
    if (load) begin
      out_status_q <= ld_status;
      out_byte_q   <= ld_byte;
      out_bvalid_q <= ld_bvalid;
      out_last_q   <= ld_last;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {6'd0, out_byte_q, out_status_q};
  assign m_axis_tuser_o  = out_bvalid_q;
  assign m_axis_tlast_o  = out_last_q;

  // the table never grows past its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(ENTRIES))
    else $error("entry count beyond table depth");

  // a newline always leaves the idle state for handling
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ch == CH_NEWLINE) |=> state_q != ST_IDLE)
    else $error("newline not handled");

  // results without a value character always close the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_bvalid_q) |-> out_last_q)
    else $error("status result without last mark");

  // a put result follows a completed copy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUT_FIN) |-> $past(state_q) == ST_COPY)
    else $error("put finished without copy");

endmodule

>>> tb/line_command_key_value_store_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_command_key_value_store_core_test
// Self-checking bench: streams put/get command lines into the core, predicts
// every status and value byte, and checks the output stream in order.
// ----------------------------------------------------------------------------
module line_command_key_value_store_core_test;
  import lckv_pkg::*;

  localparam int unsigned STALL_LIMIT = 40000;

  typedef struct {
    status_e    st;
    logic [7:0] vb;
    logic       bv;
    logic       last;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data = 8'h00;
  logic        out_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  line_command_key_value_store_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (in_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // predictor copy of the parser and table
  phase_e     cur_phase;
  logic       cmd_is_put;
  int         cmd_pos;
  logic [7:0] cur_key [KEY_CHARS];
  int         cur_key_len;
  logic [7:0] cur_val [VAL_CHARS];
  int         cur_val_len;
  logic [7:0] tbl_key [ENTRIES][KEY_CHARS];
  int         tbl_key_len [ENTRIES];
  logic [7:0] tbl_val [ENTRIES][VAL_CHARS];
  int         tbl_val_len [ENTRIES];
  int         tbl_count;

  reply_t     replies [$];
  logic [7:0] pending [$];
  int         errors = 0;
  int         n_lines = 0, n_stored = 0, n_full = 0, n_found = 0, n_missing = 0;
  bit         in_taken = 0;
  int         in_gap = 0, out_gap = 0, idle_cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  task automatic push_reply(status_e st, logic [7:0] vb, logic bv, logic last);
    reply_t r;
    r.st = st; r.vb = vb; r.bv = bv; r.last = last;
    replies.push_back(r);
  endtask

  task automatic clear_line();
    cur_phase = PH_CMD;
    cmd_is_put = 1'b1;
    cmd_pos = 0;
    cur_key_len = 0;
    cur_val_len = 0;
  endtask

  task automatic take_byte(input logic [7:0] c);
    logic is_put;
    bit   hit;
    bit   same;
    int   e;
    int   j;
    if (c == CH_NEWLINE) begin
      n_lines++;
      is_put = cmd_is_put && cmd_pos == 3;
      if (cur_phase == PH_CMD) cur_key_len = 0;
      if (!is_put || cur_phase != PH_VALUE) cur_val_len = 0;
      if (is_put) begin
        if (tbl_count >= ENTRIES) begin
          push_reply(STATUS_FULL, 8'h00, 1'b0, 1'b1);
          n_full++;
        end else begin
          for (j = 0; j < cur_key_len; j++) tbl_key[tbl_count][j] = cur_key[j];
          for (j = 0; j < cur_val_len; j++) tbl_val[tbl_count][j] = cur_val[j];
          tbl_key_len[tbl_count] = cur_key_len;
          tbl_val_len[tbl_count] = cur_val_len;
          tbl_count++;
          push_reply(STATUS_STORED, 8'h00, 1'b0, 1'b1);
          n_stored++;
        end
      end else begin
        hit = 0;
        for (e = 0; e < tbl_count && !hit; e++) begin
          if (tbl_key_len[e] == cur_key_len) begin
            same = 1;
            for (j = 0; j < cur_key_len; j++)
              if (tbl_key[e][j] != cur_key[j]) same = 0;
            if (same) begin
              hit = 1;
              n_found++;
              if (tbl_val_len[e] == 0) push_reply(STATUS_FOUND, 8'h00, 1'b0, 1'b1);
              for (j = 0; j < tbl_val_len[e]; j++)
                push_reply(STATUS_FOUND, tbl_val[e][j], 1'b1, j + 1 == tbl_val_len[e]);
            end
          end
        end
        if (!hit) begin
          push_reply(STATUS_MISSING, 8'h00, 1'b0, 1'b1);
          n_missing++;
        end
      end
      clear_line();
    end else if (cur_phase == PH_CMD) begin
      if (c == CH_SPACE) cur_phase = PH_KEY;
      else if (cmd_pos < 3) begin
        if (c != PUT_WORD[cmd_pos]) cmd_is_put = 1'b0;
        cmd_pos++;
      end
    end else if (cur_phase == PH_KEY) begin
      if (c == CH_SPACE) cur_phase = PH_VALUE;
      else if (cur_key_len < KEY_CHARS) begin
        cur_key[cur_key_len] = c;
        cur_key_len++;
      end
    end else if (cmd_is_put && cmd_pos == 3 && cur_val_len < VAL_CHARS) begin
      cur_val[cur_val_len] = c;
      cur_val_len++;
    end
  endtask

  task automatic push_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) pending.push_back(s[i]);
  endtask

  function automatic logic [7:0] any_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_NEWLINE || b == CH_SPACE);
    return b;
  endfunction

  function automatic logic [7:0] pool_char();
    return 8'(8'h61 + $urandom_range(0, 3));
  endfunction

  // monitor: predicts on accepted requests, checks accepted results
  always @(posedge clk_i) begin
    reply_t exp_r;
    bit     moved;
    if (rst_ni) begin
      moved = 0;
      if (in_valid && s_axis_tready_o) begin
        take_byte(in_data);
        in_taken = 1;
        moved = 1;
      end
      if (m_axis_tvalid_o && out_ready) begin
        moved = 1;
        if (replies.size() == 0) begin
          $error("result with nothing expected: tdata %h", m_axis_tdata_o);
          errors++;
        end else begin
          exp_r = replies.pop_front();
          if (m_axis_tdata_o[1:0] !== exp_r.st) begin
            $error("status: expected %0d, got %0d", exp_r.st, m_axis_tdata_o[1:0]);
            errors++;
          end
          if (m_axis_tdata_o[9:2] !== exp_r.vb) begin
            $error("value_byte: expected %h, got %h", exp_r.vb, m_axis_tdata_o[9:2]);
            errors++;
          end
          if (m_axis_tuser_o !== exp_r.bv) begin
            $error("byte_valid: expected %b, got %b", exp_r.bv, m_axis_tuser_o);
            errors++;
          end
          if (m_axis_tlast_o !== exp_r.last) begin
            $error("last: expected %b, got %b", exp_r.last, m_axis_tlast_o);
            errors++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no traffic for %0d cycles", STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      in_taken = 0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending.size() != 0) begin
        in_data  <= pending.pop_front();
        in_valid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap = pick_gap();
      end
    end
  end

  initial begin
    int         n_bytes;
    int         n_puts;
    int         r;
    int         i;
    int         len;
    logic [7:0] long_key [$];
    clear_line();
    tbl_count = 0;

    // directed lines
    push_str("get a\n");          // empty table
    push_str("put\n");            // newline in command word, still a put
    push_str("pu a\n");           // short command word
    push_str("putx a b c\n");     // long command word, spaces in value
    push_str("get a\n");
    push_str("get \n");           // empty key matches the bare put
    pending.push_back(8'hFF);
    push_str("\n");

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    n_bytes = 0;
    n_puts  = 2;
    while (n_bytes < 200) begin
      r = $urandom_range(0, 99);
      len = pending.size();
      if (r < 40) begin
        push_str("put ");
        for (i = $urandom_range(0, 2); i > 0; i--) pending.push_back(pool_char());
        pending.push_back(CH_SPACE);
        for (i = $urandom_range(0, 4); i > 0; i--)
          pending.push_back($urandom_range(0, 3) == 0 ? CH_SPACE : any_char());
        pending.push_back(CH_NEWLINE);
        n_puts++;
      end else if (r < 78) begin
        push_str("get ");
        for (i = $urandom_range(0, 2); i > 0; i--) pending.push_back(pool_char());
        if ($urandom_range(0, 3) == 0) push_str(" junk");
        pending.push_back(CH_NEWLINE);
      end else if (r < 88) begin
        // key and value up to 36 chars, then a get with an extra tail; chars past the key limit are dropped
        long_key.delete();
        for (i = $urandom_range(28, 36); i > 0; i--) long_key.push_back(any_char());
        push_str("put ");
        foreach (long_key[k]) pending.push_back(long_key[k]);
        pending.push_back(CH_SPACE);
        for (i = $urandom_range(28, 36); i > 0; i--) pending.push_back(any_char());
        pending.push_back(CH_NEWLINE);
        push_str("get ");
        foreach (long_key[k]) pending.push_back(long_key[k]);
        for (i = $urandom_range(0, 3); i > 0; i--) pending.push_back(any_char());
        pending.push_back(CH_NEWLINE);
        n_puts++;
      end else begin
        for (i = $urandom_range(1, 10); i > 0; i--)
          pending.push_back(8'($urandom_range(0, 255)));
        pending.push_back(CH_NEWLINE);
      end
      n_bytes += pending.size() - len;
    end

    // short puts fill the table and then run into the full case
    while (n_puts < 66) begin
      push_str("put\n");
      n_puts++;
      n_bytes += 4;
    end
    push_str("get \n");

    wait (pending.size() == 0 && !in_valid && replies.size() == 0);
    repeat (200) @(posedge clk_i);
    if (replies.size() != 0) begin
      $error("%0d expected results never arrived", replies.size());
      errors++;
    end
    $display("run: %0d lines, %0d stored, %0d full, %0d found, %0d missing",
             n_lines, n_stored, n_full, n_found, n_missing);
    $display("run: random bytes, truncated keys and values, random stalls on both sides");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
